>>> src/mtph_pkg.sv
// Package: shared types, codes and defaults for the mode tracker.
`timescale 1ns / 1ps
`default_nettype none

package mtph_pkg;

    localparam int TABLE_SIZE_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;

    // Width of the sample field and of the hashed value.
    localparam int FIELD_W = 16;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef struct packed {
        logic               action;
        logic [FIELD_W-1:0] sample;
    } req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] mode_value;
        logic [FIELD_W-1:0] mode_count;
        logic               table_full;
    } resp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> src/mtph_home.sv
// Home slot unit: two-stage key modulo table size by reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none

module mtph_home
    import mtph_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  wire logic                          aclk,
    input  wire logic [FIELD_W-1:0]            key,
    output logic      [$clog2(TABLE_SIZE)-1:0] home_pos
);

    localparam int IDXW = $clog2(TABLE_SIZE);
    localparam int PW   = 2 * FIELD_W + FIELD_W;
    localparam int RW   = FIELD_W + 2;
    // floor(2^32 / TABLE_SIZE): the quotient estimate is exact or one short.
    localparam logic [2*FIELD_W-1:0] HASH_MUL =
        (2*FIELD_W)'((64'd1 << (2 * FIELD_W)) / TABLE_SIZE);

    logic [PW-1:0]      prod;
    logic [FIELD_W-1:0] quot_reg;
    logic [RW-1:0]      qt;
    logic [RW-1:0]      rem;
    logic [RW-1:0]      rem_fix;
    logic [IDXW-1:0]    pos_reg;

    assign prod = PW'(key) * PW'(HASH_MUL);

    always_ff @(posedge aclk) begin
        quot_reg <= prod[PW-1:2*FIELD_W];
    end

    // Remainder lands in [0, 2*TABLE_SIZE); one compare and subtract fixes it.
    assign qt      = RW'(quot_reg) * RW'(TABLE_SIZE);
    assign rem     = RW'(key) - qt;
    assign rem_fix = (rem >= RW'(TABLE_SIZE)) ? rem - RW'(TABLE_SIZE) : rem;

    always_ff @(posedge aclk) begin
        pos_reg <= IDXW'(rem_fix);
    end

    assign home_pos = pos_reg;

endmodule

`default_nettype wire

>>> src/mode_tracker_probe_hash.sv
// Top level: running mode over a linear-probing hash table of sample counts.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_valid / s_ready  | req_t  {action, sample}
//  m_      | out | m_valid / m_ready  | resp_t {mode_value, mode_count, table_full}
//
// An add request steps through S_HASH, S_MOD and S_READ, then probes k slots in S_CHECK
// (k from 1 to TABLE_SIZE) and ends in S_DONE; one table read per probe sets the pace.
// A clear request sweeps the table one slot a cycle, then passes through S_DONE.
// After reset the same sweep runs with s_ready low.
// The result register frees the input side: a new request is taken while a result
// still waits on m_ready; a finished request holds in S_DONE only if it is full.
`timescale 1ns / 1ps
`default_nettype none

module mode_tracker_probe_hash
    import mtph_pkg::*;
#(
    parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire req_t  s_req,
    output logic       m_valid,
    input  wire logic  m_ready,
    output resp_t      m_resp
);

    localparam int IDXW = $clog2(TABLE_SIZE);
    localparam int MW   = 1 + SAMPLE_BITS + COUNT_BITS;
    localparam logic [IDXW-1:0]       LAST_SLOT = IDXW'(TABLE_SIZE - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // Table: {used, key, count} per slot.
    logic [MW-1:0] table_mem [TABLE_SIZE];
    logic [MW-1:0] rd_data_reg;
    logic          mem_we;
    logic [IDXW-1:0] mem_waddr;
    logic [IDXW-1:0] mem_raddr;
    logic [MW-1:0] mem_wdata;

    logic                   rd_used;
    logic [SAMPLE_BITS-1:0] rd_key;
    logic [COUNT_BITS-1:0]  rd_count;
    logic [COUNT_BITS-1:0]  inc_count;

    state_t                 state_reg, state_next;
    logic [IDXW-1:0]        clr_addr_reg, clr_addr_next;
    logic                   clr_report_reg, clr_report_next;
    logic [SAMPLE_BITS-1:0] key_reg, key_next;
    logic [IDXW-1:0]        pos_reg, pos_next;
    logic [IDXW-1:0]        probe_reg, probe_next;
    logic [IDXW-1:0]        pos_inc;
    logic [SAMPLE_BITS-1:0] best_value_reg, best_value_next;
    logic [COUNT_BITS-1:0]  best_count_reg, best_count_next;
    logic                   drop_reg, drop_next;
    logic                   m_valid_reg, m_valid_next;
    resp_t                  m_resp_reg, m_resp_next;

    logic [IDXW-1:0]        home_pos;

    mtph_home #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_home (
        .aclk     (aclk),
        .key      (FIELD_W'(key_reg)),
        .home_pos (home_pos)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[mem_raddr];
    end

    assign rd_used  = rd_data_reg[MW-1];
    assign rd_key   = rd_data_reg[MW-2 -: SAMPLE_BITS];
    assign rd_count = rd_data_reg[COUNT_BITS-1:0];
    assign inc_count = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_ONE;
    assign pos_inc   = (pos_reg == LAST_SLOT) ? '0 : pos_reg + IDXW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            clr_report_reg <= 1'b0;
            best_value_reg <= '0;
            best_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clr_report_reg <= clr_report_next;
            best_value_reg <= best_value_next;
            best_count_reg <= best_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        probe_reg  <= probe_next;
        drop_reg   <= drop_next;
        m_resp_reg <= m_resp_next;
    end

    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        clr_report_next = clr_report_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        probe_next      = probe_reg;
        best_value_next = best_value_reg;
        best_count_next = best_count_reg;
        drop_next       = drop_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_resp_next     = m_resp_reg;
        s_ready         = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = pos_reg;
        mem_wdata       = {1'b1, key_reg, COUNT_ONE};
        mem_raddr       = pos_reg;

        case (state_reg)
            S_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + IDXW'(1);
                if (clr_addr_reg == LAST_SLOT) begin
                    clr_addr_next = '0;
                    state_next    = clr_report_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    drop_next  = 1'b0;
                    probe_next = '0;
                    if (s_req.action == ACT_ADD) begin
                        key_next   = SAMPLE_BITS'(s_req.sample);
                        state_next = S_HASH;
                    end else begin
                        clr_report_next = 1'b1;
                        best_value_next = '0;
                        best_count_next = '0;
                        state_next      = S_CLEAR;
                    end
                end
            end
            S_HASH: begin
                state_next = S_MOD;
            end
            S_MOD: begin
                state_next = S_READ;
            end
            S_READ: begin
                mem_raddr  = home_pos;
                pos_next   = home_pos;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (!rd_used) begin
                    // Free slot: insert with count one.
                    mem_we = 1'b1;
                    if (best_count_reg == '0) begin
                        best_count_next = COUNT_ONE;
                        best_value_next = key_reg;
                    end
                    state_next = S_DONE;
                end else if (rd_key == key_reg) begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b1, key_reg, inc_count};
                    if (inc_count > best_count_reg) begin
                        best_count_next = inc_count;
                        best_value_next = key_reg;
                    end
                    state_next = S_DONE;
                end else if (probe_reg == LAST_SLOT) begin
                    // Every slot visited: drop the value.
                    drop_next  = 1'b1;
                    state_next = S_DONE;
                end else begin
                    mem_raddr  = pos_inc;
                    pos_next   = pos_inc;
                    probe_next = probe_reg + IDXW'(1);
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_resp_next.mode_value = FIELD_W'(best_value_reg);
                    m_resp_next.mode_count = FIELD_W'(best_count_reg);
                    m_resp_next.table_full = drop_reg;
                    clr_report_next        = 1'b0;
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_resp  = m_resp_reg;

    // One request at a time: ready drops right after an accept.
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // The mode count only grows until a clear request.
    a_best_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready && s_req.action == ACT_CLEAR)
            |=> best_count_reg >= $past(best_count_reg))
        else $error("mode count decreased without a clear");

    // A dropped value means the table is full, so a mode exists.
    a_drop_has_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && drop_reg |-> best_count_reg != '0)
        else $error("table full reported with an empty mode");

    // A result is loaded only when the output register is free or being emptied.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready && state_reg == S_DONE |=> state_reg == S_DONE)
        else $error("pending result overwritten");

endmodule

`default_nettype wire
